@@ design/sorted_byte_list_defines.svh @@
// Assertion macros used by the checker of the sorted byte list.
`ifndef SORTED_BYTE_LIST_DEFINES_SVH
`define SORTED_BYTE_LIST_DEFINES_SVH

// Antecedent and consequent checked at the same clock edge.
`define SBL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the clock edge after the antecedent.
`define SBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sbl_pkg.sv @@
// Types and codes shared by the sorted byte list design.
package sbl_pkg;

  localparam int COUNT_W = 6;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LOAD
  } sbl_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] value;
  } sbl_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
    logic [COUNT_W-1:0] removed_count;
    logic [7:0]         prev_value;
    logic               has_prev;
    logic [7:0]         next_value;
    logic               has_next;
  } sbl_rsp_t;

endpackage

@@ design/sbl_req_if.sv @@
// Valid/ready channel that carries operation requests.
interface sbl_req_if;
  import sbl_pkg::*;

  logic     valid;
  logic     ready;
  sbl_req_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/sbl_rsp_if.sv @@
// Valid/ready channel that carries operation results.
interface sbl_rsp_if;
  import sbl_pkg::*;

  logic     valid;
  logic     ready;
  sbl_rsp_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/sorted_byte_list.sv @@
// Sorted byte list: holds up to CAPACITY byte values in ascending order in a
// single-port-write, single-port-read memory. Each accepted request (insert,
// delete all equal, search) yields one result. The list is walked by one
// read pointer, one entry per cycle, with a compare unit on the registered
// read data: insert walks down from the top and moves larger entries up by
// one, delete compacts the list in place, search stops at the first entry
// past the last match or at the end of the list. A full insert or an unused
// opcode skips the walk and goes straight to loading the result. Requests
// are not overlapped: in_chan.ready is high only while no operation is in
// progress, and a finished result may wait in the output register while the
// next request is accepted. No clearing pass is needed after reset.
module sorted_byte_list #(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sbl_req_if.sink   in_chan,
  sbl_rsp_if.source out_chan
);
  import sbl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [7:0] mem [CAPACITY];

  sbl_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_left_r, rd_left_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          rvalid_r, rvalid_nxt;
  logic [7:0]    rdata_r;
  logic          out_valid_r, out_valid_nxt;
  sbl_rsp_t      out_data_r, out_data_nxt;

  logic [1:0]    op_r, op_nxt;
  logic [7:0]    val_r, val_nxt;
  logic [CW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] removed_r, removed_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic          found_r, found_nxt;
  logic [7:0]    last_r, last_nxt;
  logic          last_vld_r, last_vld_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic          hasp_r, hasp_nxt;
  logic [7:0]    next_r, next_nxt;
  logic          hasn_r, hasn_nxt;

  logic          rd_en;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          finish;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rd_left_nxt    = rd_left_r;
    rd_addr_nxt    = rd_addr_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_data_nxt   = out_data_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    wr_ptr_nxt     = wr_ptr_r;
    removed_nxt    = removed_r;
    res_status_nxt = res_status_r;
    found_nxt      = found_r;
    last_nxt       = last_r;
    last_vld_nxt   = last_vld_r;
    prev_nxt       = prev_r;
    hasp_nxt       = hasp_r;
    next_nxt       = next_r;
    hasn_nxt       = hasn_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    finish         = 1'b0;

    rd_en = (state_r == S_SCAN) && (rd_left_r != '0);
    if (rd_en) begin
      rd_left_nxt = rd_left_r - CW'(1);
      rd_addr_nxt = (op_r == OP_INSERT) ? rd_addr_r - AW'(1) : rd_addr_r + AW'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt         = in_chan.data.opcode;
          val_nxt        = in_chan.data.value;
          removed_nxt    = '0;
          res_status_nxt = ST_DONE;
          found_nxt      = 1'b0;
          last_vld_nxt   = 1'b0;
          prev_nxt       = '0;
          hasp_nxt       = 1'b0;
          next_nxt       = '0;
          hasn_nxt       = 1'b0;
          rd_left_nxt    = cnt_r;
          state_nxt      = S_SCAN;
          if (in_chan.data.opcode == OP_INSERT) begin
            // Insert walks downward from the last entry.
            wr_ptr_nxt  = cnt_r;
            rd_addr_nxt = AW'(cnt_r - CW'(1));
            if (cnt_r >= CW'(CAPACITY)) begin
              res_status_nxt = ST_FULL;
              rd_left_nxt    = '0;
              state_nxt      = S_LOAD;
            end
          end else begin
            wr_ptr_nxt  = '0;
            rd_addr_nxt = '0;
            if (in_chan.data.opcode != OP_DELETE && in_chan.data.opcode != OP_SEARCH) begin
              rd_left_nxt = '0;
              state_nxt   = S_LOAD;
            end
          end
        end
      end

      S_SCAN: begin
        unique case (op_r)
          OP_INSERT: begin
            mem_waddr = wr_ptr_r[AW-1:0];
            if (rvalid_r && rdata_r > val_r) begin
              mem_we     = 1'b1;
              mem_wdata  = rdata_r;
              wr_ptr_nxt = wr_ptr_r - CW'(1);
            end else if (rvalid_r || rd_left_r == '0) begin
              // Hole found, or every entry was larger than the new value.
              mem_we    = 1'b1;
              mem_wdata = val_r;
              cnt_nxt   = cnt_r + CW'(1);
              finish    = 1'b1;
            end
          end
          OP_DELETE: begin
            if (rvalid_r) begin
              if (rdata_r == val_r) begin
                removed_nxt = removed_r + CW'(1);
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = wr_ptr_r[AW-1:0];
                mem_wdata  = rdata_r;
                wr_ptr_nxt = wr_ptr_r + CW'(1);
              end
            end else if (rd_left_r == '0) begin
              cnt_nxt        = wr_ptr_r;
              res_status_nxt = (removed_r == '0) ? ST_NOT_FOUND : ST_DONE;
              finish         = 1'b1;
            end
          end
          OP_SEARCH: begin
            if (rvalid_r) begin
              if (!found_r) begin
                if (rdata_r == val_r) begin
                  found_nxt = 1'b1;
                  prev_nxt  = last_vld_r ? last_r : 8'd0;
                  hasp_nxt  = last_vld_r;
                end
                last_nxt     = rdata_r;
                last_vld_nxt = 1'b1;
              end else if (rdata_r != val_r) begin
                next_nxt = rdata_r;
                hasn_nxt = 1'b1;
                finish   = 1'b1;
              end
            end else if (rd_left_r == '0) begin
              res_status_nxt = found_r ? ST_DONE : ST_NOT_FOUND;
              finish         = 1'b1;
            end
          end
          default: finish = 1'b1;
        endcase
        if (finish) begin
          rd_left_nxt = '0;
          state_nxt   = S_LOAD;
        end
      end

      S_LOAD: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = res_status_r;
          out_data_nxt.entry_count   = COUNT_W'(cnt_r);
          out_data_nxt.removed_count = COUNT_W'(removed_r);
          out_data_nxt.prev_value    = prev_r;
          out_data_nxt.has_prev      = hasp_r;
          out_data_nxt.next_value    = next_r;
          out_data_nxt.has_next      = hasn_r;
          state_nxt                  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // A read issued in the cycle the scan ends is dropped.
    rvalid_nxt = rd_en && !finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_left_r   <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rd_left_r   <= rd_left_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    out_data_r   <= out_data_nxt;
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    wr_ptr_r     <= wr_ptr_nxt;
    removed_r    <= removed_nxt;
    res_status_r <= res_status_nxt;
    found_r      <= found_nxt;
    last_r       <= last_nxt;
    last_vld_r   <= last_vld_nxt;
    prev_r       <= prev_nxt;
    hasp_r       <= hasp_nxt;
    next_r       <= next_nxt;
    hasn_r       <= hasn_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr_r];
    end
  end

endmodule

@@ design/sbl_checker.sv @@
// Port-level checks for the sorted byte list and their binding to it.
`include "sorted_byte_list_defines.svh"

module sbl_checker #(
  parameter int CAPACITY = 32
) (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input sbl_pkg::sbl_rsp_t out_data
);
  import sbl_pkg::*;

  `SBL_ASSERT_NEXT(a_out_valid_holds, out_valid && !out_ready, out_valid, "result dropped before its transfer")
  `SBL_ASSERT_NEXT(a_out_data_holds, out_valid && !out_ready, $stable(out_data), "stalled result changed")
  `SBL_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready, "request taken while busy")
  `SBL_ASSERT_SAME(a_full_count, out_valid && out_data.status == ST_FULL, out_data.entry_count == COUNT_W'(CAPACITY), "full status with a list that is not full")
  `SBL_ASSERT_SAME(a_not_found_empty, out_valid && out_data.status == ST_NOT_FOUND, !out_data.has_prev && !out_data.has_next && out_data.removed_count == '0, "miss reported with neighbors or removals")

endmodule

bind sorted_byte_list sbl_checker #(.CAPACITY(CAPACITY)) u_sbl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

@@ test/sorted_byte_list_tb.sv @@
// Self-checking testbench for the sorted byte list: directed rows, then random phases.
`timescale 1ns / 1ps

module sorted_byte_list_tb;
  import sbl_pkg::*;

  localparam int CAPACITY = 32;
  localparam int LIMIT = 600000;
  localparam int SETTLE_CYCLES = CAPACITY + 8;
  localparam int RANDOM_ITEMS = 1200;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } phase_kind_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] value;
    logic       typed;
    sbl_rsp_t   rsp;
  } stim_row_t;

  localparam sbl_rsp_t NO_RSP = '0;

  // Rows with typed set carry an expectation that can be read off directly.
  localparam int N_ROWS = 21;
  localparam stim_row_t DIRECTED_ROWS[N_ROWS] = '{
    '{OP_SEARCH, 8'd0,   1'b1, '{ST_NOT_FOUND, 6'd0, 6'd0, 8'd0, 1'b0, 8'd0, 1'b0}},
    '{OP_DELETE, 8'd255, 1'b1, '{ST_NOT_FOUND, 6'd0, 6'd0, 8'd0, 1'b0, 8'd0, 1'b0}},
    '{OP_UNUSED, 8'd255, 1'b1, '{ST_DONE,      6'd0, 6'd0, 8'd0, 1'b0, 8'd0, 1'b0}},
    '{OP_INSERT, 8'd0,   1'b1, '{ST_DONE,      6'd1, 6'd0, 8'd0, 1'b0, 8'd0, 1'b0}},
    '{OP_INSERT, 8'd255, 1'b1, '{ST_DONE,      6'd2, 6'd0, 8'd0, 1'b0, 8'd0, 1'b0}},
    '{OP_INSERT, 8'd255, 1'b1, '{ST_DONE,      6'd3, 6'd0, 8'd0, 1'b0, 8'd0, 1'b0}},
    '{OP_INSERT, 8'd128, 1'b1, '{ST_DONE,      6'd4, 6'd0, 8'd0, 1'b0, 8'd0, 1'b0}},
    '{OP_INSERT, 8'd0,   1'b1, '{ST_DONE,      6'd5, 6'd0, 8'd0, 1'b0, 8'd0, 1'b0}},
    '{OP_SEARCH, 8'd255, 1'b0, NO_RSP},
    '{OP_SEARCH, 8'd0,   1'b0, NO_RSP},
    '{OP_SEARCH, 8'd128, 1'b0, NO_RSP},
    '{OP_SEARCH, 8'd127, 1'b1, '{ST_NOT_FOUND, 6'd5, 6'd0, 8'd0, 1'b0, 8'd0, 1'b0}},
    '{OP_DELETE, 8'd127, 1'b1, '{ST_NOT_FOUND, 6'd5, 6'd0, 8'd0, 1'b0, 8'd0, 1'b0}},
    '{OP_UNUSED, 8'd0,   1'b1, '{ST_DONE,      6'd5, 6'd0, 8'd0, 1'b0, 8'd0, 1'b0}},
    '{OP_DELETE, 8'd255, 1'b0, NO_RSP},
    '{OP_DELETE, 8'd0,   1'b0, NO_RSP},
    '{OP_SEARCH, 8'd128, 1'b0, NO_RSP},
    '{OP_INSERT, 8'd170, 1'b0, NO_RSP},
    '{OP_INSERT, 8'd85,  1'b0, NO_RSP},
    '{OP_DELETE, 8'd128, 1'b0, NO_RSP},
    '{OP_SEARCH, 8'd85,  1'b0, NO_RSP}
  };

  logic clk;
  logic rst_n;

  sbl_req_if in_chan();
  sbl_rsp_if out_chan();

  sorted_byte_list #(.CAPACITY(CAPACITY)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Shadow copy of the list, ascending, and the results still owed by the block.
  logic [7:0] held[$];
  sbl_rsp_t   owed_results[$];

  int unsigned errors;
  int unsigned results_seen;
  int unsigned cycle_count;
  int unsigned n_insert, n_delete, n_search, n_unused, n_full, n_missing;
  int          stall_left;
  bit          quiet;
  logic [7:0]  pool_lo;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    end
  endtask

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      note_failure($sformatf("%s expected %0d, got %0d", name, exp_v, act_v));
    end
  endtask

  task automatic check_result(input sbl_rsp_t exp_r, input sbl_rsp_t act_r);
    compare_field("status", exp_r.status, act_r.status);
    compare_field("entry_count", exp_r.entry_count, act_r.entry_count);
    compare_field("removed_count", exp_r.removed_count, act_r.removed_count);
    compare_field("prev_value", exp_r.prev_value, act_r.prev_value);
    compare_field("has_prev", exp_r.has_prev, act_r.has_prev);
    compare_field("next_value", exp_r.next_value, act_r.next_value);
    compare_field("has_next", exp_r.has_next, act_r.has_next);
  endtask

  // Applies one operation to the shadow list and returns the result it owes.
  function automatic sbl_rsp_t apply_list_op(input logic [1:0] op, input logic [7:0] v);
    sbl_rsp_t   r;
    logic [7:0] kept[$];
    int         i;
    int         j;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (held.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          i = 0;
          while (i < held.size() && held[i] <= v) i++;
          held.insert(i, v);
        end
      end
      OP_DELETE: begin
        foreach (held[k]) begin
          if (held[k] == v) r.removed_count = r.removed_count + 1'b1;
          else kept.push_back(held[k]);
        end
        held = kept;
        if (r.removed_count == 0) r.status = ST_NOT_FOUND;
      end
      OP_SEARCH: begin
        i = 0;
        while (i < held.size() && held[i] != v) i++;
        if (i >= held.size()) begin
          r.status = ST_NOT_FOUND;
        end else begin
          if (i > 0) begin
            r.prev_value = held[i-1];
            r.has_prev = 1'b1;
          end
          j = i;
          while (j < held.size() && held[j] == v) j++;
          if (j < held.size()) begin
            r.next_value = held[j];
            r.has_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.entry_count = COUNT_W'(held.size());
    return r;
  endfunction

  // Mostly short gaps, a few long enough to span a whole scan of the list.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drives one request, waits for its transfer and records what it owes.
  task automatic send_item(input logic [1:0] op, input logic [7:0] v, input bit typed,
                           input sbl_rsp_t typed_rsp, input int gap);
    sbl_rsp_t predicted;
    in_chan.valid <= 1'b1;
    in_chan.data  <= {op, v};
    do @(posedge clk); while (!in_chan.ready);
    predicted = apply_list_op(op, v);
    owed_results.push_back(typed ? typed_rsp : predicted);
    case (op)
      OP_INSERT: n_insert++;
      OP_DELETE: n_delete++;
      OP_SEARCH: n_search++;
      default:   n_unused++;
    endcase
    if (predicted.status == ST_FULL) n_full++;
    if (predicted.status == ST_NOT_FOUND) n_missing++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Favors values already held so that deletes and searches hit often.
  function automatic logic [7:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40 && held.size() != 0) return held[$urandom_range(0, held.size() - 1)];
    if (r < 65) return pool_lo + 8'($urandom_range(0, 7));
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: return 8'd0;
        1: return 8'd255;
        2: return 8'd127;
        default: return 8'd128;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [1:0] pick_op(input phase_kind_t kind);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (kind)
      PH_FILL: begin
        if (r < 80) return OP_INSERT;
        if (r < 90) return OP_SEARCH;
        if (r < 97) return OP_DELETE;
      end
      PH_DRAIN: begin
        if (r < 55) return OP_DELETE;
        if (r < 90) return OP_SEARCH;
        if (r < 95) return OP_INSERT;
      end
      default: begin
        if (r < 45) return OP_INSERT;
        if (r < 65) return OP_DELETE;
        if (r < 95) return OP_SEARCH;
      end
    endcase
    return OP_UNUSED;
  endfunction

  // Result side: checks each transfer and applies random backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (owed_results.size() == 0) begin
          note_failure("result with no request outstanding");
        end else begin
          check_result(owed_results.pop_front(), out_chan.data);
        end
        results_seen++;
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (quiet || $urandom_range(0, 99) < 75) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= 1'b0;
        stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 3);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int          issued;
    int          phase_len;
    phase_kind_t kind;
    clk = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    out_chan.ready = 1'b0;
    errors = 0;
    results_seen = 0;
    cycle_count = 0;
    quiet = 1'b0;
    pool_lo = 8'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[n]) begin
      send_item(DIRECTED_ROWS[n].opcode, DIRECTED_ROWS[n].value, DIRECTED_ROWS[n].typed,
                DIRECTED_ROWS[n].rsp, pick_gap());
    end

    // The first phase fills the list so that full inserts appear early.
    issued = 0;
    kind = PH_FILL;
    while (issued < RANDOM_ITEMS) begin
      wait_drained();
      quiet = ($urandom_range(0, 3) == 0);
      pool_lo = 8'($urandom_range(0, 248));
      phase_len = $urandom_range(60, 140);
      repeat (phase_len) begin
        send_item(pick_op(kind), pick_value(), 1'b0, NO_RSP, pick_gap());
        issued++;
      end
      kind = phase_kind_t'($urandom_range(0, 2));
    end

    wait_drained();
    quiet = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d inserts (%0d on a full list), %0d deletes,",
             results_seen, n_insert, n_full, n_delete);
    $display("%0d searches, %0d unused opcodes, %0d misses, %0d mismatches.",
             n_search, n_unused, n_missing, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
